FILE: src/fqck_pkg.sv
// ----------------------------------------------------------------------------
// fqck_pkg
// shared types and constants of the keyed fifo queue with cancel
// ----------------------------------------------------------------------------
package fqck_pkg;

  localparam int unsigned KeyW     = 32;
  localparam int unsigned PayloadW = 8;
  localparam int unsigned CmdW     = 2;
  localparam int unsigned StatusW  = 2;

  typedef enum logic [CmdW-1:0] {
    CMD_PUSH   = 2'd0,
    CMD_CANCEL = 2'd1,
    CMD_POP    = 2'd2
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  // command broadcast to every cell, already qualified by the input transfer
  typedef struct packed {
    logic                push;
    logic                cancel;
    logic                pop;
    logic [KeyW-1:0]     key;
    logic [PayloadW-1:0] payload;
  } cell_ctrl_t;

endpackage

FILE: src/fqck_cell.sv
// ----------------------------------------------------------------------------
// fqck_cell
// one queue slot: holds key and payload, compares on cancel, shifts forward
// ----------------------------------------------------------------------------
module fqck_cell (
  input  logic                              clk_i,
  input  logic                              occupied_i,
  input  logic                              tail_i,
  input  fqck_pkg::cell_ctrl_t              ctrl_i,
  input  logic [fqck_pkg::KeyW-1:0]         nxt_key_i,
  input  logic [fqck_pkg::PayloadW-1:0]     nxt_payload_i,
  input  logic                              hit_i,
  input  logic [fqck_pkg::PayloadW-1:0]     sel_payload_i,
  output logic [fqck_pkg::KeyW-1:0]         key_o,
  output logic [fqck_pkg::PayloadW-1:0]     payload_o,
  output logic                              hit_o,
  output logic [fqck_pkg::PayloadW-1:0]     sel_payload_o
);
  import fqck_pkg::*;

  logic [KeyW-1:0]     key_d, key_q;
  logic [PayloadW-1:0] payload_d, payload_q;
  logic                match;
  logic                shift_en;

  assign match         = ctrl_i.cancel & occupied_i & (key_q == ctrl_i.key);
  assign hit_o         = hit_i | match;
  // first match from the head hands its payload down the chain
  assign sel_payload_o = (match & ~hit_i) ? payload_q : sel_payload_i;
  // on pop all slots, on cancel the removed one and all behind, move headward
  assign shift_en      = ctrl_i.pop | (ctrl_i.cancel & hit_o);

  always_comb begin
    key_d     = key_q;
    payload_d = payload_q;
    if (ctrl_i.push && tail_i) begin
      key_d     = ctrl_i.key;
      payload_d = ctrl_i.payload;
    end else if (shift_en) begin
      key_d     = nxt_key_i;
      payload_d = nxt_payload_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    payload_q <= payload_d;
  end

  assign key_o     = key_q;
  assign payload_o = payload_q;

endmodule

FILE: src/fifo_queue_with_cancel_by_key.sv
// ----------------------------------------------------------------------------
// fifo_queue_with_cancel_by_key
// bounded fifo of keyed entries with push, pop and cancel by key
// ----------------------------------------------------------------------------
// usage
//   input stream: s_axis_tuser carries the command (push, cancel, pop),
//   s_axis_tdata the key and the payload. every command except the unused
//   code 3 gives one result transfer on the output stream: m_axis_tuser is
//   the status, m_axis_tdata the key and payload removed (zero otherwise)
//   and the occupancy after the command.
//   latency: the result is valid the cycle after the input transfer.
//   throughput: one command per cycle; the slot row compares all keys at
//   once and shifts in the same cycle, so the chain of cells sets the pace.
//   reset clears the occupancy and the output valid; slot contents are not
//   cleared, only occupied slots are ever read.
//   when the receiver stalls, the result waits in the output register and
//   s_axis_tready drops until that result is taken; a new command is taken
//   in the same cycle the waiting result leaves.
// ----------------------------------------------------------------------------
module fifo_queue_with_cancel_by_key #(
  parameter int unsigned QUEUE_DEPTH = 16,
  localparam int unsigned CntW       = $clog2(QUEUE_DEPTH + 1),
  localparam int unsigned InDataW    = ((fqck_pkg::KeyW + fqck_pkg::PayloadW + 7) / 8) * 8,
  localparam int unsigned OutDataW   =
    ((fqck_pkg::KeyW + fqck_pkg::PayloadW + CntW + 7) / 8) * 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [InDataW-1:0]              s_axis_tdata,  // entry_key, entry_payload
  input  logic [fqck_pkg::CmdW-1:0]       s_axis_tuser,  // command
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [OutDataW-1:0]             m_axis_tdata,  // result_key, result_payload,
                                                         // occupancy, zero pad
  output logic [fqck_pkg::StatusW-1:0]    m_axis_tuser   // status
);
  import fqck_pkg::*;

  // input decode
  logic                in_xfer;
  cmd_e                cmd;
  logic [KeyW-1:0]     in_key;
  logic [PayloadW-1:0] in_payload;
  logic                full, empty;
  cell_ctrl_t          ctrl;

  // occupancy and output register
  logic [CntW-1:0]     count_d, count_q;
  logic                out_valid_d, out_valid_q;
  logic                res_valid;
  status_e             status_d, status_q;
  logic [KeyW-1:0]     rkey_d, rkey_q;
  logic [PayloadW-1:0] rpay_d, rpay_q;

  // cell row
  logic [KeyW-1:0]     cell_key [QUEUE_DEPTH];
  logic [PayloadW-1:0] cell_pay [QUEUE_DEPTH];
  logic                hit_c    [QUEUE_DEPTH+1];
  logic [PayloadW-1:0] selp_c   [QUEUE_DEPTH+1];

  assign s_axis_tready = ~out_valid_q | m_axis_tready;
  assign in_xfer       = s_axis_tvalid & s_axis_tready;
  assign cmd           = cmd_e'(s_axis_tuser);
  assign in_key        = s_axis_tdata[KeyW-1:0];
  assign in_payload    = s_axis_tdata[KeyW+PayloadW-1:KeyW];
  assign full          = (count_q == CntW'(QUEUE_DEPTH));
  assign empty         = (count_q == '0);

  assign ctrl.push    = in_xfer & (cmd == CMD_PUSH) & ~full;
  assign ctrl.cancel  = in_xfer & (cmd == CMD_CANCEL);
  assign ctrl.pop     = in_xfer & (cmd == CMD_POP) & ~empty;
  assign ctrl.key     = in_key;
  assign ctrl.payload = in_payload;

  // head of the search chain: nothing found yet
  assign hit_c[0]  = 1'b0;
  assign selp_c[0] = '0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [KeyW-1:0]     nxt_key;
    logic [PayloadW-1:0] nxt_pay;

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign nxt_key = '0;
      assign nxt_pay = '0;
    end else begin : g_mid
      assign nxt_key = cell_key[i+1];
      assign nxt_pay = cell_pay[i+1];
    end

    fqck_cell u_cell (
      .clk_i         (clk_i),
      .occupied_i    (CntW'(i) < count_q),
      .tail_i        (count_q == CntW'(i)),
      .ctrl_i        (ctrl),
      .nxt_key_i     (nxt_key),
      .nxt_payload_i (nxt_pay),
      .hit_i         (hit_c[i]),
      .sel_payload_i (selp_c[i]),
      .key_o         (cell_key[i]),
      .payload_o     (cell_pay[i]),
      .hit_o         (hit_c[i+1]),
      .sel_payload_o (selp_c[i+1])
    );
  end

  // result and next occupancy
  always_comb begin
    res_valid = 1'b0;
    status_d  = ST_DONE;
    rkey_d    = '0;
    rpay_d    = '0;
    count_d   = count_q;
    unique case (cmd)
      CMD_PUSH: begin
        res_valid = 1'b1;
        if (full) begin
          status_d = ST_FULL;
        end else begin
          count_d = count_q + 1'b1;
        end
      end
      CMD_CANCEL: begin
        res_valid = 1'b1;
        if (hit_c[QUEUE_DEPTH]) begin
          rkey_d  = in_key;
          rpay_d  = selp_c[QUEUE_DEPTH];
          count_d = count_q - 1'b1;
        end else begin
          status_d = ST_NOT_FOUND;
        end
      end
      CMD_POP: begin
        res_valid = 1'b1;
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          rkey_d  = cell_key[0];
          rpay_d  = cell_pay[0];
          count_d = count_q - 1'b1;
        end
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  // the unused command code leaves everything as it was
  assign out_valid_d = (in_xfer & res_valid) | (out_valid_q & ~m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        count_q <= count_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && res_valid) begin
      status_q <= status_d;
      rkey_q   <= rkey_d;
      rpay_q   <= rpay_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = status_q;
  assign m_axis_tdata  = OutDataW'({count_q, rpay_q, rkey_q});

endmodule

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the keyed fifo queue with cancel by key
// ----------------------------------------------------------------------------
// a short directed sequence walks the queue through empty, full, duplicate
// keys and a cancel of the last occupied slot; random command streams then
// swing the occupancy between empty and full. a scoreboard keeps its own
// copy of the queue, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fqck_pkg::*;

  localparam int unsigned Depth    = 16;
  localparam int unsigned CntW     = $clog2(Depth + 1);
  localparam int unsigned InDataW  = ((KeyW + PayloadW + 7) / 8) * 8;
  localparam int unsigned OutDataW = ((KeyW + PayloadW + CntW + 7) / 8) * 8;
  localparam int unsigned NumRandom  = 1050;
  localparam int unsigned CycleLimit = 500000;
  localparam int unsigned DrainWait  = 8;
  localparam int unsigned MaxReports = 10;
  // code 3 is not a member of cmd_e: the block drops it without a result
  localparam logic [CmdW-1:0] CmdUnused = 2'd3;

  // --------------------------------------------------------------------------
  // scoreboard: shadow queue plus the results still owed by the block
  // --------------------------------------------------------------------------
  typedef struct packed {
    logic [KeyW-1:0]     key;
    logic [PayloadW-1:0] payload;
  } entry_t;

  typedef struct packed {
    logic [StatusW-1:0]  status;
    logic [KeyW-1:0]     key;
    logic [PayloadW-1:0] payload;
    logic [CntW-1:0]     occupancy;
  } outcome_t;

  class fqck_scoreboard;
    entry_t   entries[$];
    outcome_t owed[$];
    int       errors;

    function new();
      errors = 0;
    endfunction

    function int pending();
      return owed.size();
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= MaxReports) $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    // update the shadow queue for one command transfer, queue its result
    function void note_command(logic [CmdW-1:0] cmd, logic [KeyW-1:0] key,
                               logic [PayloadW-1:0] payload);
      outcome_t res;
      int       hit;
      res = '0;
      hit = -1;
      case (cmd)
        CMD_PUSH: begin
          if (entries.size() >= Depth) begin
            res.status = ST_FULL;
          end else begin
            entries.push_back('{key: key, payload: payload});
            res.status = ST_DONE;
          end
        end
        CMD_CANCEL: begin
          // first match counted from the head, last occupied slot included
          foreach (entries[i]) begin
            if (hit < 0 && entries[i].key == key) hit = i;
          end
          if (hit < 0) begin
            res.status = ST_NOT_FOUND;
          end else begin
            res.status  = ST_DONE;
            res.key     = entries[hit].key;
            res.payload = entries[hit].payload;
            entries.delete(hit);
          end
        end
        CMD_POP: begin
          if (entries.size() == 0) begin
            res.status = ST_EMPTY;
          end else begin
            res.status  = ST_DONE;
            res.key     = entries[0].key;
            res.payload = entries[0].payload;
            void'(entries.pop_front());
          end
        end
        default: return;  // unused code, no result
      endcase
      res.occupancy = CntW'(entries.size());
      owed.push_back(res);
    endfunction

    function void check_result(outcome_t got);
      outcome_t exp;
      if (owed.size() == 0) begin
        flag($sformatf("unexpected result status=%0d key=%h payload=%h occ=%0d",
                       got.status, got.key, got.payload, got.occupancy));
        return;
      end
      exp = owed.pop_front();
      if (got.status !== exp.status || got.key !== exp.key ||
          got.payload !== exp.payload || got.occupancy !== exp.occupancy) begin
        flag($sformatf({"exp status=%0d key=%h payload=%h occ=%0d, ",
                        "got status=%0d key=%h payload=%h occ=%0d"},
                       exp.status, exp.key, exp.payload, exp.occupancy,
                       got.status, got.key, got.payload, got.occupancy));
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and the block
  // --------------------------------------------------------------------------
  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;   // entry_key, entry_payload
  logic [CmdW-1:0]     s_axis_tuser;   // command
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;   // result_key, result_payload, occupancy, zero pad
  logic [StatusW-1:0]  m_axis_tuser;   // status

  fqck_scoreboard      queue_sb;
  int unsigned         cycles = 0;
  int unsigned         burst_left;
  logic [KeyW-1:0]     key_pool[8];

  always #1 clk_i = ~clk_i;

  fifo_queue_with_cancel_by_key #(
    .QUEUE_DEPTH(Depth)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // --------------------------------------------------------------------------
  // monitor: results are checked before the same edge's command is noted,
  // a command never gives its result at the edge it is accepted
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        queue_sb.check_result('{status:    m_axis_tuser,
                                key:       m_axis_tdata[KeyW-1:0],
                                payload:   m_axis_tdata[KeyW +: PayloadW],
                                occupancy: m_axis_tdata[KeyW+PayloadW +: CntW]});
      end
      if (s_axis_tvalid && s_axis_tready) begin
        queue_sb.note_command(s_axis_tuser, s_axis_tdata[KeyW-1:0],
                              s_axis_tdata[KeyW +: PayloadW]);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // receiver: alternating ready and stall runs, some long free stretches
  // --------------------------------------------------------------------------
  initial begin
    int unsigned run;
    bit          rdy;
    rdy = 1'b0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      rdy = ~rdy;
      if (rdy) begin
        run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 12);
      end else begin
        run = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 40);
      end
      @(negedge clk_i);
      m_axis_tready <= rdy;
      repeat (run - 1) @(negedge clk_i);
    end
  end

  // --------------------------------------------------------------------------
  // sender
  // --------------------------------------------------------------------------
  // idle cycles before the next command: mostly none, a few long gaps
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      burst_left = $urandom_range(30, 80);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // one command transfer; returns at the edge where it is taken
  task automatic send_cmd(logic [CmdW-1:0] cmd, logic [KeyW-1:0] key,
                          logic [PayloadW-1:0] payload);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= InDataW'({payload, key});
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // empty and full corners, duplicate keys, cancel of the tail slot
  task automatic run_directed();
    send_cmd(CMD_POP, 32'h0, 8'h00);            // pop on empty queue
    send_cmd(CMD_CANCEL, 32'hFFFF_FFFF, 8'hFF); // cancel on empty queue
    send_cmd(CmdUnused, 32'h1234_5678, 8'h5A);  // dropped, no result
    send_cmd(CMD_PUSH, 32'h0, 8'h00);
    send_cmd(CMD_PUSH, 32'hFFFF_FFFF, 8'hFF);
    for (int i = 0; i < Depth - 3; i++) begin
      // same key twice so cancel has to pick the one nearer the head
      send_cmd(CMD_PUSH, (i == 4 || i == 9) ? 32'hA5A5_0001 : 32'h0100_0000 + i,
               8'(8'h10 + i));
    end
    send_cmd(CMD_PUSH, 32'hC0DE_0016, 8'h77);   // fills the last slot
    send_cmd(CMD_PUSH, 32'hDEAD_BEEF, 8'h3C);   // push on full queue
    send_cmd(CMD_CANCEL, 32'hC0DE_0016, 8'h00); // match in the last occupied slot
    send_cmd(CMD_CANCEL, 32'hA5A5_0001, 8'h00); // first of the duplicates
    send_cmd(CMD_CANCEL, 32'h5555_AAAA, 8'h00); // no match on a busy queue
    send_cmd(CMD_CANCEL, 32'h0, 8'h00);         // match at the head
    send_cmd(CMD_POP, 32'h0, 8'h00);
  endtask

  task automatic run_random();
    int unsigned done_cnt;
    int unsigned phase_left;
    int unsigned r;
    bit          filling;
    logic [CmdW-1:0]     cmd;
    logic [KeyW-1:0]     key;
    logic [PayloadW-1:0] payload;
    done_cnt   = 0;
    phase_left = 0;
    filling    = 1'b1;
    foreach (key_pool[i]) key_pool[i] = $urandom();
    while (done_cnt < NumRandom) begin
      // alternate fill-biased and drain-biased phases so both ends are hit
      if (phase_left == 0) begin
        filling    = ~filling;
        phase_left = $urandom_range(30, 80);
        key_pool[$urandom_range(0, 7)] = $urandom();
      end
      phase_left--;
      r = $urandom_range(0, 99);
      if (r < 3)                       cmd = CmdUnused;
      else if (r < (filling ? 70 : 30)) cmd = CMD_PUSH;
      else if (r < (filling ? 85 : 65)) cmd = CMD_CANCEL;
      else                             cmd = CMD_POP;
      payload = PayloadW'($urandom_range(0, 255));
      r = $urandom_range(0, 99);
      if (cmd == CMD_CANCEL && r < 60 && queue_sb.entries.size() > 0) begin
        key = queue_sb.entries[$urandom_range(0, queue_sb.entries.size() - 1)].key;
      end else if (r < 80) begin
        key = key_pool[$urandom_range(0, 7)];
      end else begin
        key = $urandom();
      end
      send_cmd(cmd, key, payload);
      if (cmd != CmdUnused) done_cnt++;
    end
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    burst_left    = 0;
    queue_sb      = new();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    run_directed();
    run_random();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    // wait for every owed result, then a few cycles for strays
    while (queue_sb.pending() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (queue_sb.errors == 0 && queue_sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
